@@ rtl/sbmd_pkg.sv @@
// Shared types, constants and the centimeter lookup for the stereo blob matcher.
// No dependencies; imported by the matcher top level.
package sbmd_pkg;

    // Default sizing
    localparam int MAX_BLOBS_DEF = 32;
    localparam int X_BITS_DEF    = 10;
    localparam int AREA_BITS_DEF = 17;

    // Field widths on the stream ports
    localparam int XPOS_W   = 10;
    localparam int AREA_W   = 17;
    localparam int IDX_OUT_W = 5;
    localparam int DEPTH_W  = 10;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP   = 2'd2;

    localparam logic [DEPTH_W-1:0] MIN_DISP_RST = 10'd60;
    localparam logic [DEPTH_W-1:0] MAX_DISP_RST = 10'd300;

    // Centimeter table: below min_disparity is 10 cm, the band from it 11 cm; the
    // last one ends at max_disparity (30 cm); these are the fixed steps between
    localparam int MAX_CM = 30;
    localparam int CM_MID_N = 19;
    localparam logic [DEPTH_W-1:0] CM_MID [CM_MID_N] = '{
        10'd74,  10'd83,  10'd98,  10'd105, 10'd112, 10'd120, 10'd129,
        10'd136, 10'd142, 10'd147, 10'd153, 10'd158, 10'd162, 10'd167,
        10'd170, 10'd175, 10'd178, 10'd182, 10'd185
    };

    // One result beat
    typedef struct packed {
        logic                 valid_res;
        logic                 short_side;
        logic [IDX_OUT_W-1:0] short_index;
        logic [IDX_OUT_W-1:0] long_index;
        logic [DEPTH_W-1:0]   depth;
        logic                 done_res;
    } res_t;

    // Map an inverted disparity to centimeters; the lowest matching band wins,
    // and a value outside every band passes through raw.
    function automatic logic [DEPTH_W-1:0] to_cm(input logic [DEPTH_W-1:0] d,
                                                 input logic [DEPTH_W-1:0] dmin,
                                                 input logic [DEPTH_W-1:0] dmax);
        logic [DEPTH_W-1:0] res;
        res = d;
        if (CM_MID[CM_MID_N-1] <= d && d < dmax) res = DEPTH_W'(MAX_CM);
        for (int i = 28; i >= 11; i--) begin
            if (CM_MID[i-11] <= d && d < CM_MID[i-10]) res = DEPTH_W'(i + 1);
        end
        if (dmin <= d && d < CM_MID[0]) res = DEPTH_W'(11);
        if (d < dmin) res = DEPTH_W'(10);
        return res;
    endfunction

endpackage

@@ rtl/sbmd_blob_mem.sv @@
// Blob store for one camera: one write port, one read port, registered read.
// No dependencies; instantiated twice by the matcher top level.
module sbmd_blob_mem #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5,
    parameter int WIDTH = 27
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/stereo_blob_match_depth.sv @@
// Stereo blob matcher: loads blobs per camera (one beat per cycle while loading), then greedy matching.
// After the last beat each shorter-list entry scans the whole longer list for its match;
// input is held off until the closing beat is issued, and result stalls can delay that.
// Reset (aresetn, synchronous, low): lists empty, overflow clear, registers
// calib_mode=0, min_disparity=60, max_disparity=300. Depends on sbmd_pkg.
module stereo_blob_match_depth
    import sbmd_pkg::*;
#(
    parameter int MAX_BLOBS = MAX_BLOBS_DEF,
    parameter int X_BITS    = X_BITS_DEF,
    parameter int AREA_BITS = AREA_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // x_pos[9:0], area[26:10], zero pad
    input  logic                  s_tuser,   // side (0 right, 1 left)
    input  logic                  s_tlast,   // last blob of the frame pair
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // short_index[4:0], long_index[9:5],
                                             // depth[19:10], dropped[20], zero pad
    output logic [M_TUSER_W-1:0]  m_tuser,   // valid_res[0], short_side[1]
    output logic                  m_tlast,   // done_res
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W  = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOBS + 1);
    localparam int WORD_W = X_BITS + AREA_BITS;
    localparam int DW     = (X_BITS > DEPTH_W) ? X_BITS : DEPTH_W;

    // Sequencer codes
    localparam logic [3:0] ST_LOAD   = 4'd0;  // take blobs
    localparam logic [3:0] ST_START  = 4'd1;  // pick short side, clear flags
    localparam logic [3:0] ST_SCAN   = 4'd2;  // issue long-list reads
    localparam logic [3:0] ST_DRAIN  = 4'd3;  // compare the last read
    localparam logic [3:0] ST_EVAL   = 4'd4;  // column difference
    localparam logic [3:0] ST_CHECK  = 4'd5;  // disparity window, inversion
    localparam logic [3:0] ST_MAP    = 4'd6;  // depth mapping, push result
    localparam logic [3:0] ST_NEXT   = 4'd7;  // next short entry
    localparam logic [3:0] ST_FINISH = 4'd8;  // last beat of the frame

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               calib_mode_reg;
    logic [DEPTH_W-1:0] min_disp_reg;
    logic [DEPTH_W-1:0] max_disp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_mode_reg <= 1'b0;
            min_disp_reg   <= MIN_DISP_RST;
            max_disp_reg   <= MAX_DISP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CALIB_MODE: calib_mode_reg <= cfg_wdata[0];
                CFG_MIN_DISP:   min_disp_reg   <= cfg_wdata;
                CFG_MAX_DISP:   max_disp_reg   <= cfg_wdata;
                default: ;      // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] right_count_reg, left_count_reg;
    logic             overflow_reg;
    logic             short_side_reg;
    logic [CNT_W-1:0] ns_reg, nl_reg;
    logic [CNT_W-1:0] j_reg;        // short-list entry in work
    logic [CNT_W-1:0] scan_i_reg;   // long-list read address
    logic             cmp_vld_reg;  // read data of cmp_idx_reg arrives now
    logic [CNT_W-1:0] cmp_idx_reg;
    logic             found_reg;
    logic [MAX_BLOBS-1:0] assigned_reg;
    logic             have_pend_reg;
    logic             m_tvalid_reg;

    // Datapath registers
    logic [AREA_BITS-1:0] best_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [X_BITS-1:0]    best_x_reg;
    logic [X_BITS-1:0]    dx_reg;
    logic [DEPTH_W-1:0]   d_reg;
    res_t                 pend_reg;
    res_t                 out_reg;
    logic                 out_dropped_reg;

    // ------------------------------------------------------------------
    // Blob memories: word = {area, x}
    // ------------------------------------------------------------------
    logic                 s_beat;
    logic [X_BITS-1:0]    x_in;
    logic [AREA_BITS-1:0] area_in;
    logic                 right_we, left_we;
    logic [IDX_W-1:0]     right_raddr, left_raddr;
    logic [WORD_W-1:0]    right_rdata, left_rdata;
    logic [WORD_W-1:0]    wdata;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_beat   = s_tvalid && s_tready;
    assign x_in     = X_BITS'(s_tdata[XPOS_W-1:0]);
    assign area_in  = AREA_BITS'(s_tdata[XPOS_W+AREA_W-1:XPOS_W]);
    assign wdata    = {area_in, x_in};

    assign right_we = s_beat && !s_tuser && (right_count_reg < CNT_W'(MAX_BLOBS));
    assign left_we  = s_beat &&  s_tuser && (left_count_reg  < CNT_W'(MAX_BLOBS));

    // short list sits at j, long list walks scan_i
    assign right_raddr = short_side_reg ? scan_i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign left_raddr  = short_side_reg ? j_reg[IDX_W-1:0] : scan_i_reg[IDX_W-1:0];

    sbmd_blob_mem #(
        .DEPTH (MAX_BLOBS),
        .IDX_W (IDX_W),
        .WIDTH (WORD_W)
    ) u_right_mem (
        .aclk  (aclk),
        .we    (right_we),
        .waddr (right_count_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    sbmd_blob_mem #(
        .DEPTH (MAX_BLOBS),
        .IDX_W (IDX_W),
        .WIDTH (WORD_W)
    ) u_left_mem (
        .aclk  (aclk),
        .we    (left_we),
        .waddr (left_count_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    // Split read data into short and long entry
    logic [WORD_W-1:0]    short_word, long_word;
    logic [X_BITS-1:0]    short_x, long_x;
    logic [AREA_BITS-1:0] short_area, long_area;

    assign short_word = short_side_reg ? left_rdata : right_rdata;
    assign long_word  = short_side_reg ? right_rdata : left_rdata;
    assign short_x    = short_word[X_BITS-1:0];
    assign short_area = short_word[WORD_W-1:X_BITS];
    assign long_x     = long_word[X_BITS-1:0];
    assign long_area  = long_word[WORD_W-1:X_BITS];

    // ------------------------------------------------------------------
    // Compare, window and mapping logic
    // ------------------------------------------------------------------
    logic [AREA_BITS-1:0] area_err;
    logic                 take_cand;
    logic [DW-1:0]        dx_ext, min_ext, max_ext;
    logic                 in_window;
    logic [DEPTH_W-1:0]   depth_new;
    logic                 out_busy;
    logic                 emit_pend;   // held-back pair moves to the result port
    logic                 emit_close;  // closing beat of the frame moves out
    res_t                 new_res;
    res_t                 close_res;

    assign area_err  = (short_area > long_area) ? (short_area - long_area)
                                                : (long_area - short_area);
    assign take_cand = cmp_vld_reg && !assigned_reg[cmp_idx_reg[IDX_W-1:0]] &&
                       (!found_reg || (area_err < best_reg));

    assign dx_ext    = DW'(dx_reg);
    assign min_ext   = DW'(min_disp_reg);
    assign max_ext   = DW'(max_disp_reg);
    assign in_window = (dx_ext >= min_ext) && (dx_ext <= max_ext);

    assign depth_new = calib_mode_reg ? d_reg : to_cm(d_reg, min_disp_reg, max_disp_reg);
    assign out_busy  = m_tvalid_reg && !m_tready;

    assign emit_pend  = (state_reg == ST_MAP) && have_pend_reg && !out_busy;
    assign emit_close = (state_reg == ST_FINISH) && !out_busy;

    always_comb begin
        new_res             = '0;
        new_res.valid_res   = 1'b1;
        new_res.short_side  = short_side_reg;
        new_res.short_index = IDX_OUT_W'(j_reg);
        new_res.long_index  = IDX_OUT_W'(pos_reg);
        new_res.depth       = depth_new;
        new_res.done_res    = 1'b0;
    end

    // closing beat: the held-back pair, or an invalid beat when no pair was made
    always_comb begin
        close_res          = have_pend_reg ? pend_reg : '0;
        close_res.done_res = 1'b1;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_beat && s_tlast) state_next = ST_START;
            end
            ST_START: begin
                if (right_count_reg == '0 || left_count_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_i_reg == nl_reg - CNT_W'(1)) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_EVAL;
            ST_EVAL: begin
                state_next = found_reg ? ST_CHECK : ST_NEXT;
            end
            ST_CHECK: begin
                state_next = in_window ? ST_MAP : ST_NEXT;
            end
            ST_MAP: begin
                if (!(have_pend_reg && out_busy)) state_next = ST_NEXT;
            end
            ST_NEXT: begin
                state_next = (j_reg == ns_reg - CNT_W'(1)) ? ST_FINISH : ST_SCAN;
            end
            ST_FINISH: begin
                if (!out_busy) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            right_count_reg <= '0;
            left_count_reg  <= '0;
            overflow_reg    <= 1'b0;
            short_side_reg  <= 1'b0;
            ns_reg          <= '0;
            nl_reg          <= '0;
            j_reg           <= '0;
            scan_i_reg      <= '0;
            cmp_vld_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            found_reg       <= 1'b0;
            assigned_reg    <= '0;
            have_pend_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            // read data of this cycle's address is compared next cycle
            cmp_vld_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg <= scan_i_reg;

            // hold a stalled beat, raise valid when a new beat is loaded
            m_tvalid_reg <= emit_pend || emit_close || out_busy;

            if (take_cand) found_reg <= 1'b1;

            case (state_reg)
                ST_LOAD: begin
                    // store the blob, or flag it when its list is full
                    if (s_beat) begin
                        if (right_we) right_count_reg <= right_count_reg + CNT_W'(1);
                        if (left_we)  left_count_reg  <= left_count_reg + CNT_W'(1);
                        if (!right_we && !left_we) overflow_reg <= 1'b1;
                    end
                end
                ST_START: begin
                    // left is shorter only when strictly shorter
                    short_side_reg <= (right_count_reg > left_count_reg);
                    if (right_count_reg > left_count_reg) begin
                        ns_reg <= left_count_reg;
                        nl_reg <= right_count_reg;
                    end else begin
                        ns_reg <= right_count_reg;
                        nl_reg <= left_count_reg;
                    end
                    assigned_reg <= '0;
                    j_reg        <= '0;
                    scan_i_reg   <= '0;
                    found_reg    <= 1'b0;
                end
                ST_SCAN: begin
                    if (scan_i_reg != nl_reg - CNT_W'(1)) begin
                        scan_i_reg <= scan_i_reg + CNT_W'(1);
                    end
                end
                ST_CHECK: begin
                    if (in_window) assigned_reg[pos_reg[IDX_W-1:0]] <= 1'b1;
                end
                ST_MAP: begin
                    // hold back the newest pair until we know whether it ends the frame
                    if (!(have_pend_reg && out_busy)) begin
                        have_pend_reg <= 1'b1;
                    end
                end
                ST_NEXT: begin
                    j_reg      <= j_reg + CNT_W'(1);
                    scan_i_reg <= '0;
                    found_reg  <= 1'b0;
                end
                ST_FINISH: begin
                    // emit the closing beat, then clear the lists for the next frame
                    if (!out_busy) begin
                        have_pend_reg   <= 1'b0;
                        right_count_reg <= '0;
                        left_count_reg  <= '0;
                        overflow_reg    <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (take_cand) begin
            best_reg   <= area_err;
            pos_reg    <= cmp_idx_reg;
            best_x_reg <= long_x;
        end
        if (state_reg == ST_EVAL) begin
            dx_reg <= (short_x > best_x_reg) ? (short_x - best_x_reg)
                                             : (best_x_reg - short_x);
        end
        if (state_reg == ST_CHECK) begin
            d_reg <= DEPTH_W'(max_ext - dx_ext);
        end
        if (state_reg == ST_MAP && !(have_pend_reg && out_busy)) begin
            pend_reg <= new_res;
        end
        if (emit_pend) begin
            out_reg         <= pend_reg;
            out_dropped_reg <= overflow_reg;
        end
        if (emit_close) begin
            out_reg         <= close_res;
            out_dropped_reg <= overflow_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_dropped_reg, out_reg.depth,
                       out_reg.long_index, out_reg.short_index};
    assign m_tuser  = {out_reg.short_side, out_reg.valid_res};
    assign m_tlast  = out_reg.done_res;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_i_reg < nl_reg))
        else $error("long-list read address beyond list length");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (right_count_reg <= CNT_W'(MAX_BLOBS)) && (left_count_reg <= CNT_W'(MAX_BLOBS)))
        else $error("blob count beyond capacity");

    a_no_pend_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> !have_pend_reg)
        else $error("held-back pair left over after frame end");

    a_finish_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && state_next == ST_LOAD) |=> (m_tvalid && m_tlast))
        else $error("frame end without closing beat");

endmodule

@@ test/stereo_blob_match_depth_test.sv @@
// Self-checking testbench for the stereo blob matcher: streams camera blobs, predicts
// the matched pairs and depths, and checks every result beat field by field.
// Depends on sbmd_pkg and the stereo_blob_match_depth RTL with its sbmd_blob_mem.
module stereo_blob_match_depth_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sbmd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int IDLE_PCT     = 31;
    localparam int DRAIN_CYCLES = 40;
    localparam int BLOB_SLOTS   = MAX_BLOBS_DEF;
    localparam int X_MAX        = (1 << XPOS_W) - 1;
    localparam int AREA_MAX     = (1 << AREA_W) - 1;

    // One blob as it travels on the input stream
    typedef struct packed {
        bit                side;
        bit [XPOS_W-1:0]   x;
        bit [AREA_W-1:0]   area;
        bit                last;
    } blob_t;

    // One result beat; logic so that unknown outputs never compare equal
    typedef struct packed {
        logic                 valid_res;
        logic                 short_side;
        logic [IDX_OUT_W-1:0] short_index;
        logic [IDX_OUT_W-1:0] long_index;
        logic [DEPTH_W-1:0]   depth;
        logic                 dropped;
        logic                 done_res;
    } depth_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // x_pos[9:0], area[26:10], zero pad
    logic                  s_tuser   = 1'b0; // side
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // short_index, long_index, depth, dropped
    logic [M_TUSER_W-1:0]  m_tuser;          // valid_res[0], short_side[1]
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Stimulus and expectations
    blob_t         blobs_to_send[$];
    depth_result_t depth_results_due[$];
    blob_t         blob_in_flight;
    blob_t         next_blob;
    bit            s_fire = 1'b0;
    bit            steady = 1'b0;

    // Predictor copy of the block: per-camera stores, counts and registers
    bit [XPOS_W-1:0] cam_x    [2][BLOB_SLOTS];
    bit [AREA_W-1:0] cam_area [2][BLOB_SLOTS];
    int              cam_count[2] = '{0, 0};
    bit              blob_overflow = 1'b0;
    bit              calib_on = 1'b0;
    int              disp_min = int'(MIN_DISP_RST);
    int              disp_max = int'(MAX_DISP_RST);

    // Run statistics
    int cycles_run      = 0;
    int mismatches      = 0;
    int beats_loaded    = 0;
    int frames_closed   = 0;
    int pairs_due       = 0;
    int empty_frames    = 0;
    int overflow_frames = 0;
    int results_checked = 0;
    int settings_used   = 1;

    stereo_blob_match_depth dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Inverted disparity to centimeters: band i spans [edge i, edge i+1) and
    // reports i+1; the lowest band wins, and a value in no band passes raw.
    // Edges 0..9 are zero, edge ten is min_disparity, edge thirty max_disparity.
    function automatic bit [DEPTH_W-1:0] disparity_to_cm(int d);
        int band [MAX_CM+1];
        for (int i = 0; i <= MAX_CM; i++) begin
            if (i < 10)
                band[i] = 0;
            else if (i == 10)
                band[i] = disp_min;
            else if (i < MAX_CM)
                band[i] = int'(CM_MID[i-11]);
            else
                band[i] = disp_max;
        end
        for (int i = 0; i < MAX_CM; i++) begin
            if (d >= band[i] && d < band[i+1])
                return DEPTH_W'(i + 1);
        end
        return DEPTH_W'(d);
    endfunction

    // Load one accepted blob; on the frame's last blob run the greedy area
    // match and queue the result beats that the block owes for this frame.
    task automatic match_blob_pairs(blob_t b);
        int s_side, l_side, ns, nl, best, pos, diff, dx, d, made;
        bit found;
        bit taken [BLOB_SLOTS];
        depth_result_t r;
        beats_loaded++;
        // a full list refuses the blob but remembers the loss for the frame
        if (cam_count[b.side] < BLOB_SLOTS) begin
            cam_x[b.side][cam_count[b.side]]    = b.x;
            cam_area[b.side][cam_count[b.side]] = b.area;
            cam_count[b.side]++;
        end else begin
            blob_overflow = 1'b1;
        end
        if (!b.last)
            return;

        frames_closed++;
        if (blob_overflow)
            overflow_frames++;
        // right camera is the short list unless it holds strictly more blobs
        s_side = (cam_count[0] > cam_count[1]) ? 1 : 0;
        l_side = 1 - s_side;
        ns     = cam_count[s_side];
        nl     = cam_count[l_side];
        made   = 0;
        foreach (taken[i])
            taken[i] = 1'b0;

        if (ns != 0 && nl != 0) begin
            for (int j = 0; j < ns; j++) begin
                found = 1'b0;
                best  = 0;
                pos   = 0;
                for (int i = 0; i < nl; i++) begin
                    if (!taken[i]) begin
                        diff = int'(cam_area[s_side][j]) - int'(cam_area[l_side][i]);
                        if (diff < 0)
                            diff = -diff;
                        // strict compare keeps the lowest index on a tie
                        if (!found || diff < best) begin
                            best  = diff;
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    dx = int'(cam_x[s_side][j]) - int'(cam_x[l_side][pos]);
                    if (dx < 0)
                        dx = -dx;
                    // out-of-range disparity leaves both entries free
                    if (dx >= disp_min && dx <= disp_max) begin
                        d             = disp_max - dx;
                        taken[pos]    = 1'b1;
                        r.valid_res   = 1'b1;
                        r.short_side  = s_side[0];
                        r.short_index = j[IDX_OUT_W-1:0];
                        r.long_index  = pos[IDX_OUT_W-1:0];
                        r.depth       = calib_on ? DEPTH_W'(d) : disparity_to_cm(d);
                        r.dropped     = blob_overflow;
                        r.done_res    = 1'b0;
                        depth_results_due.insert(depth_results_due.size(), r);
                        made++;
                    end
                end
            end
        end

        // a frame without pairs still answers with one invalid beat
        if (made == 0) begin
            r          = '0;
            r.dropped  = blob_overflow;
            r.done_res = 1'b1;
            depth_results_due.insert(depth_results_due.size(), r);
            empty_frames++;
        end else begin
            depth_results_due[depth_results_due.size()-1].done_res = 1'b1;
            pairs_due += made;
        end
        cam_count[0]  = 0;
        cam_count[1]  = 0;
        blob_overflow = 1'b0;
    endtask

    task automatic check_field(string name, logic [DEPTH_W-1:0] want, logic [DEPTH_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: result %0d %s mismatch, expected %0d, got %0d",
                     $time, results_checked, name, want, got);
        end
    endtask

    // Sample both handshakes at the rising edge: check result beats against
    // the oldest expectation, then feed accepted blobs to the predictor.
    always @(posedge aclk) begin : result_check
        depth_result_t got;
        depth_result_t want;
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d blobs unsent, %0d results still due",
                     $time, blobs_to_send.size(), depth_results_due.size());
            $display("stereo_blob_match_depth verification failed");
            $finish;
        end else begin
            s_fire = aresetn && s_tvalid && s_tready;
            if (aresetn && m_tvalid && m_tready) begin
                got = '{m_tuser[0], m_tuser[1], m_tdata[4:0], m_tdata[9:5],
                        m_tdata[19:10], m_tdata[20], m_tlast};
                results_checked++;
                if (depth_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, got);
                end else begin
                    want = depth_results_due.pop_front();
                    check_field("valid_res", DEPTH_W'(want.valid_res),
                                DEPTH_W'(got.valid_res));
                    check_field("short_side", DEPTH_W'(want.short_side),
                                DEPTH_W'(got.short_side));
                    check_field("short_index", DEPTH_W'(want.short_index),
                                DEPTH_W'(got.short_index));
                    check_field("long_index", DEPTH_W'(want.long_index),
                                DEPTH_W'(got.long_index));
                    check_field("depth", want.depth, got.depth);
                    check_field("dropped", DEPTH_W'(want.dropped),
                                DEPTH_W'(got.dropped));
                    check_field("done_res", DEPTH_W'(want.done_res),
                                DEPTH_W'(got.done_res));
                end
            end
            if (s_fire)
                match_blob_pairs(blob_in_flight);
        end
    end

    // Drive on the falling edge: hold a beat until it is taken, then either
    // idle or pop the next blob; stall the result side at random.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (blobs_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_blob       = blobs_to_send.pop_front();
                blob_in_flight <= next_blob;
                s_tvalid       <= 1'b1;
                s_tdata        <= S_TDATA_W'({next_blob.area, next_blob.x});
                s_tuser        <= next_blob.side;
                s_tlast        <= next_blob.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic push_blob(bit side, int x, int area, bit last);
        blob_t b;
        b = '{side, x[XPOS_W-1:0], area[AREA_W-1:0], last};
        blobs_to_send.insert(blobs_to_send.size(), b);
    endtask

    // Hold until every blob is taken and every result has come back, then
    // give the matcher time to settle before touching registers.
    task automatic wait_drained();
        while (blobs_to_send.size() != 0 || s_tvalid || depth_results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(bit calib, int lo, int hi, bit calm);
        wait_drained();
        steady = calm;
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CALIB_MODE;
        cfg_wdata <= CFG_DATA_W'(calib);
        @(negedge aclk);
        cfg_index <= CFG_MIN_DISP;
        cfg_wdata <= lo[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_index <= CFG_MAX_DISP;
        cfg_wdata <= hi[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        calib_on = calib;
        disp_min = lo;
        disp_max = hi;
        settings_used++;
    endtask

    // Build one frame pair: most left blobs shadow a right blob with a
    // disparity at or near the accepted range and a similar area, so the
    // matcher gets past its rejections; the rest are noise.
    task automatic queue_frame(int nr, int nl, bit narrow);
        blob_t rights[$];
        blob_t lefts[$];
        blob_t b;
        int lo, hi, k, disp, xv, av;
        lo = (disp_min <= disp_max) ? disp_min : disp_max;
        hi = (disp_min <= disp_max) ? disp_max : disp_min;
        for (int i = 0; i < nr; i++) begin
            b.side = 1'b0;
            b.x    = XPOS_W'($urandom_range(X_MAX));
            b.area = AREA_W'(narrow ? $urandom_range(15) : $urandom_range(AREA_MAX));
            b.last = 1'b0;
            rights.insert(rights.size(), b);
        end
        for (int i = 0; i < nl; i++) begin
            b.side = 1'b1;
            b.last = 1'b0;
            b.x    = XPOS_W'($urandom_range(X_MAX));
            b.area = AREA_W'(narrow ? $urandom_range(15) : $urandom_range(AREA_MAX));
            if (nr > 0 && $urandom_range(9) < 7) begin
                k = $urandom_range(nr - 1);
                case ($urandom_range(5))
                    0: disp = lo;
                    1: disp = hi;
                    2: disp = lo - 1;
                    3: disp = hi + 1;
                    default: disp = $urandom_range(hi, lo);
                endcase
                if (disp < 0)
                    disp = 0;
                xv = int'(rights[k].x) + disp;
                if ($urandom_range(1) || xv > X_MAX)
                    xv = int'(rights[k].x) - disp;
                if (xv < 0)
                    xv = int'(rights[k].x) + disp;
                if (xv <= X_MAX)
                    b.x = xv[XPOS_W-1:0];
                av = int'(rights[k].area) + int'($urandom_range(40)) - 20;
                if (av < 0)
                    av = 0;
                if (av > AREA_MAX)
                    av = AREA_MAX;
                b.area = av[AREA_W-1:0];
            end
            lefts.insert(lefts.size(), b);
        end
        // interleave the cameras, keeping each camera's own order
        while (rights.size() + lefts.size() != 0) begin
            if (lefts.size() == 0 || (rights.size() != 0 && $urandom_range(1)))
                b = rights.pop_front();
            else
                b = lefts.pop_front();
            blobs_to_send.insert(blobs_to_send.size(), b);
        end
        blobs_to_send[blobs_to_send.size()-1].last = 1'b1;
    endtask

    // Mostly small frames so matching stays short; now and then a full-size one
    task automatic queue_random(int items);
        int added, nr, nl;
        added = 0;
        @(posedge aclk);
        while (added < items) begin
            if ($urandom_range(11) == 0) begin
                nr = $urandom_range(BLOB_SLOTS);
                nl = $urandom_range(BLOB_SLOTS);
            end else begin
                nr = $urandom_range(5);
                nl = $urandom_range(5);
            end
            if (nr + nl == 0)
                nr = 1;
            queue_frame(nr, nl, $urandom_range(2) == 0);
            added += nr + nl;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames under the reset settings (no calibration, 60..300)
        // one camera empty: single invalid beat either way
        push_blob(0, 0, 0, 1);
        push_blob(1, X_MAX, AREA_MAX, 1);
        // disparity far beyond the maximum: no pair
        push_blob(0, 0, AREA_MAX, 0);
        push_blob(1, X_MAX, 0, 1);
        // equal counts, right is short; equal area distance goes to index zero
        push_blob(0, 100, 500, 0);
        push_blob(0, 400, 1000, 0);
        push_blob(1, 200, 700, 0);
        push_blob(1, 300, 700, 1);
        // right holds more blobs, left is short; depth below min maps to ten
        push_blob(0, 210, 1000, 0);
        push_blob(0, 900, 5, 0);
        push_blob(1, 500, 1000, 0);
        push_blob(0, 10, 99999, 1);
        // disparity exactly at min and at max
        push_blob(0, 0, 10, 0);
        push_blob(1, 60, 10, 0);
        push_blob(0, X_MAX, 50000, 0);
        push_blob(1, X_MAX - 300, 50000, 1);
        // disparity one below min, then one above max: both rejected
        push_blob(1, 500, 42, 0);
        push_blob(0, 441, 42, 1);
        push_blob(0, 0, 7, 0);
        push_blob(1, 301, 7, 1);
        // depth on either side of the first fixed band edge
        push_blob(0, 500, 3, 0);
        push_blob(1, 727, 3, 0);
        push_blob(0, 100, 9000, 0);
        push_blob(1, 326, 9000, 1);

        // Random frames across register settings, extremes included
        queue_random(40);
        apply_settings(1'b1, 0, X_MAX, 1'b1);       // raw output, widest range, no stalls
        queue_random(40);
        apply_settings(1'b0, 0, X_MAX, 1'b0);       // full table, zero disparity goes raw
        queue_random(40);
        apply_settings(1'b0, 100, 200, 1'b0);       // min above the first fixed edge
        queue_random(40);
        apply_settings(1'b0, 500, 100, 1'b0);       // inverted range: never a pair
        queue_random(30);
        apply_settings(1'b1, X_MAX, X_MAX, 1'b0);   // only the widest disparity
        queue_random(25);
        apply_settings(1'b0, 0, 0, 1'b0);           // only zero disparity
        queue_random(40);
        apply_settings(1'b0, int'(MIN_DISP_RST), int'(MAX_DISP_RST), 1'b0);
        queue_random(35);
        // overflow: a full camera refuses the rest, a refused last blob still closes the frame
        queue_frame(BLOB_SLOTS + 2, 3, 1'b0);
        queue_frame(2, BLOB_SLOTS + 1, 1'b0);
        queue_random(10);

        wait_drained();
        $display("checked %0d result beats from %0d blob beats in %0d frames, %0d settings",
                 results_checked, beats_loaded, frames_closed, settings_used);
        $display("%0d matched pairs, %0d frames without a pair, %0d frames with dropped blobs",
                 pairs_due, empty_frames, overflow_frames);
        if (mismatches == 0)
            $display("stereo_blob_match_depth verification clean");
        else
            $display("stereo_blob_match_depth verification failed");
        $finish;
    end

endmodule
